/* hdl/lwe_pkg.sv */
`timescale 1ns / 1ps

package lwe_pkg;

    // File layout
    localparam int HEADER_BYTES      = 54;
    localparam int SIG_BYTES         = 72;
    localparam int LEN_BYTES         = 32;
    localparam int MAX_MESSAGE_CHARS = 65536;

    // First byte of the message body; the position counter stops here
    localparam int BODY_START = HEADER_BYTES + SIG_BYTES + LEN_BYTES;
    localparam int POS_W      = $clog2(BODY_START + 1);
    localparam int CNT_W      = $clog2(MAX_MESSAGE_CHARS + 1);
    localparam int LEN_W      = 32;

    typedef enum logic [2:0] {
        ST_CHAR     = 3'd0,
        ST_NO_SIG   = 3'd1,
        ST_TOO_LONG = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_TRUNC    = 3'd4
    } t_status;

    typedef struct packed {
        logic lsb;
        logic file_end;
    } t_item;

    typedef struct packed {
        logic [7:0] message_char;
        t_status    status;
        logic       last;
    } t_result;

    // Expected signature "watermark", one character per index
    function automatic logic [7:0] sig_char(input logic [3:0] k);
        logic [7:0] c;
        case (k)
            4'd0:    c = 8'h77; // w
            4'd1:    c = 8'h61; // a
            4'd2:    c = 8'h74; // t
            4'd3:    c = 8'h65; // e
            4'd4:    c = 8'h72; // r
            4'd5:    c = 8'h6D; // m
            4'd6:    c = 8'h61; // a
            4'd7:    c = 8'h72; // r
            4'd8:    c = 8'h6B; // k
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

/* hdl/lwe_if.sv */
`timescale 1ns / 1ps

interface lwe_item_if;
    logic       valid;
    logic       ready;
    logic [7:0] file_byte;
    logic       file_end;

    modport source (output valid, output file_byte, output file_end, input ready);
    modport sink   (input valid, input file_byte, input file_end, output ready);
endinterface

interface lwe_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] message_char;
    logic [2:0] status;
    logic       last;

    modport source (output valid, output message_char, output status, output last,
                    input ready);
    modport sink   (input valid, input message_char, input status, input last,
                    output ready);
endinterface

/* hdl/lwe_in_reg.sv */
`timescale 1ns / 1ps

module lwe_in_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lwe_item_if.sink      i_item,
    input  logic          i_take,    // core consumes the held byte this cycle
    output logic          o_valid,
    output lwe_pkg::t_item o_item
);
    import lwe_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign i_item.ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_item.lsb      <= i_item.file_byte[0];
            r_item.file_end <= i_item.file_end;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

/* hdl/lwe_core.sv */
`timescale 1ns / 1ps

module lwe_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  lwe_pkg::t_item  i_item,
    output logic            o_res_valid,
    output lwe_pkg::t_result o_res
);
    import lwe_pkg::*;

    localparam logic [POS_W-1:0] SIG_START  = POS_W'(HEADER_BYTES);
    localparam logic [POS_W-1:0] LEN_START  = POS_W'(HEADER_BYTES + SIG_BYTES);
    localparam logic [POS_W-1:0] BODY_POS   = POS_W'(BODY_START);
    localparam logic [LEN_W-1:0] MAX_LEN    = LEN_W'(MAX_MESSAGE_CHARS);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_shift, n_shift;
    logic             r_sig_ok, n_sig_ok;
    logic [LEN_W-1:0] r_len, n_len;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [2:0]       r_idx, n_idx;
    logic             r_done, n_done;

    logic [POS_W-1:0] sig_off;
    logic [POS_W-1:0] len_off;
    logic [7:0]       ch;
    logic             ok_now;

    assign sig_off = r_pos - SIG_START;
    assign len_off = r_pos - LEN_START;
    assign ch      = {i_item.lsb, r_shift[7:1]};

    always_comb begin
        n_pos       = r_pos;
        n_shift     = r_shift;
        n_sig_ok    = r_sig_ok;
        n_len       = r_len;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_done      = r_done;
        ok_now      = r_sig_ok;
        o_res_valid = 1'b0;
        o_res       = '{message_char: 8'h00, status: ST_CHAR, last: 1'b0};

        if (i_fire) begin
            if (!r_done) begin
                if (r_pos < SIG_START) begin
                    n_pos = r_pos + 1'b1;
                end else if (r_pos < LEN_START) begin
                    n_shift = ch;
                    if (sig_off[2:0] == 3'd7) begin
                        ok_now = r_sig_ok && (ch == sig_char(sig_off[6:3]));
                        if (sig_off[6:3] == 4'd8 && !ok_now) begin
                            o_res_valid = 1'b1;
                            o_res       = '{message_char: 8'h00, status: ST_NO_SIG,
                                            last: 1'b1};
                            n_done      = 1'b1;
                        end
                    end
                    n_sig_ok = ok_now;
                    n_pos    = r_pos + 1'b1;
                end else if (r_pos < BODY_POS) begin
                    // length arrives LSB first: shift in from the top
                    n_len = {i_item.lsb, r_len[LEN_W-1:1]};
                    if (len_off[4:0] == 5'd31) begin
                        if (n_len > MAX_LEN) begin
                            o_res_valid = 1'b1;
                            o_res       = '{message_char: 8'h00, status: ST_TOO_LONG,
                                            last: 1'b1};
                            n_done      = 1'b1;
                        end else if (n_len == '0) begin
                            o_res_valid = 1'b1;
                            o_res       = '{message_char: 8'h00, status: ST_EMPTY,
                                            last: 1'b1};
                            n_done      = 1'b1;
                        end
                    end
                    n_pos = r_pos + 1'b1;
                end else begin
                    n_shift = ch;
                    n_idx   = r_idx + 1'b1;
                    if (r_idx == 3'd7) begin
                        // length is known to be within bound here
                        n_cnt       = r_cnt + 1'b1;
                        o_res_valid = 1'b1;
                        o_res       = '{message_char: ch, status: ST_CHAR,
                                        last: (n_cnt >= r_len[CNT_W-1:0])};
                        n_done      = (n_cnt >= r_len[CNT_W-1:0]);
                    end
                end

                // early end gives a truncation unless this byte already ended the file
                if (i_item.file_end && !n_done) begin
                    o_res_valid = 1'b1;
                    o_res       = '{message_char: 8'h00, status: ST_TRUNC, last: 1'b1};
                end
            end

            if (i_item.file_end) begin
                n_pos    = '0;
                n_sig_ok = 1'b1;
                n_cnt    = '0;
                n_idx    = '0;
                n_done   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_sig_ok <= 1'b1;
            r_cnt    <= '0;
            r_idx    <= '0;
            r_done   <= 1'b0;
        end else begin
            r_pos    <= n_pos;
            r_sig_ok <= n_sig_ok;
            r_cnt    <= n_cnt;
            r_idx    <= n_idx;
            r_done   <= n_done;
        end
    end

    // shift registers are fully refilled before each use
    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
        r_len   <= n_len;
    end

endmodule

/* hdl/lwe_out_reg.sv */
`timescale 1ns / 1ps

module lwe_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  lwe_pkg::t_result i_res,
    output logic             o_free,
    lwe_result_if.source     o_result
);
    import lwe_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free = !r_valid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_result.valid        = r_valid;
    assign o_result.message_char = r_res.message_char;
    assign o_result.status       = r_res.status;
    assign o_result.last         = r_res.last;

endmodule

/* hdl/lsb_watermark_extract_top.sv */
`timescale 1ns / 1ps

// Channel  | Dir | Payload                             | Transfer
// ---------+-----+-------------------------------------+--------------------
// i_item   | in  | file_byte[7:0], file_end            | valid && ready
// o_result | out | message_char[7:0], status[2:0], last| valid && ready
//
// One file byte per cycle, sustained while the result register is free. A byte
// is first held in the input register; then the extraction logic updates the
// counters and, where a result falls out, loads the result register.
// Reset (i_rst_n low, synchronous) empties both registers and returns the
// extractor to the start of a file; processing a byte with file_end set also
// returns the extractor to the start of a file, but empties no register.
// While the result register holds an unread result, the held byte waits in the
// input register, whether or not it gives a result, and i_item.ready drops.
module lsb_watermark_extract_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lwe_item_if.sink      i_item,
    lwe_result_if.source  o_result
);
    import lwe_pkg::*;

    logic    in_valid;
    t_item   in_item;
    logic    out_free;
    logic    core_fire;
    logic    res_valid;
    t_result res;

    // Held byte is processed once the result register can take its outcome
    assign core_fire = in_valid && out_free;

    lwe_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_take  (core_fire),
        .o_valid (in_valid),
        .o_item  (in_item)
    );

    // Header skip, signature check, length capture, character assembly and early-end detection
    lwe_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (core_fire),
        .i_item      (in_item),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    lwe_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (core_fire && res_valid),
        .i_res    (res),
        .o_free   (out_free),
        .o_result (o_result)
    );

endmodule

/* verif/tb_lsb_watermark_extract_top.sv */
`timescale 1ns / 1ps

module tb_lsb_watermark_extract_top;
    import lwe_pkg::*;

    // Run sizing
    localparam int ITEM_TARGET  = 2000;     // file bytes over the whole run
    localparam int HOLD_CYCLES  = 600;      // long receiver hold-off
    localparam int END_PAUSE    = 20;       // quiet cycles after the last result
    localparam int CYCLE_LIMIT  = 400000;

    localparam string WATERMARK_SIG = "watermark";

    // Scoreboard: tracks the extractor state byte by byte and queues the
    // result, if any, each accepted byte should produce.
    class WatermarkScoreboard;
        t_result    awaited[$];
        bit [19:0]  pos;
        bit [7:0]   shift;
        bit         sig_ok;
        bit [31:0]  msg_len;
        bit [16:0]  emitted;
        bit         done;
        int         mismatches;
        int         checked;
        int         status_seen[5];

        function new();
            restart();
        endfunction

        function void restart();
            pos     = '0;
            shift   = '0;
            sig_ok  = 1'b1;
            msg_len = '0;
            emitted = '0;
            done    = 1'b0;
        endfunction

        function void note_byte(logic [7:0] fb, logic fe);
            bit        lb;
            bit [19:0] off;
            bit [2:0]  idx;
            int        k;
            bit        have;
            t_result   r;
            lb   = fb[0];
            have = 1'b0;
            r    = '{message_char: 8'h00, status: ST_CHAR, last: 1'b0};
            if (!done) begin
                if (pos < HEADER_BYTES) begin
                    pos++;
                end else if (pos < HEADER_BYTES + SIG_BYTES) begin
                    off        = pos - HEADER_BYTES;
                    idx        = off[2:0];
                    shift[idx] = lb;
                    if (idx == 3'd7) begin
                        k = off >> 3;
                        if (shift != WATERMARK_SIG[k])
                            sig_ok = 1'b0;
                        shift = '0;
                        if (k == 8 && !sig_ok) begin
                            r    = '{message_char: 8'h00, status: ST_NO_SIG, last: 1'b1};
                            have = 1'b1;
                            done = 1'b1;
                        end
                    end
                    pos++;
                end else if (pos < BODY_START) begin
                    off               = pos - HEADER_BYTES - SIG_BYTES;
                    msg_len[off[4:0]] = lb;
                    if (off[4:0] == 5'd31) begin
                        if (msg_len > MAX_MESSAGE_CHARS) begin
                            r    = '{message_char: 8'h00, status: ST_TOO_LONG, last: 1'b1};
                            have = 1'b1;
                            done = 1'b1;
                        end else if (msg_len == 0) begin
                            r    = '{message_char: 8'h00, status: ST_EMPTY, last: 1'b1};
                            have = 1'b1;
                            done = 1'b1;
                        end
                    end
                    pos++;
                end else begin
                    off        = pos - BODY_START;
                    idx        = off[2:0];
                    shift[idx] = lb;
                    if (idx == 3'd7) begin
                        emitted++;
                        r     = '{message_char: shift, status: ST_CHAR,
                                  last: (emitted >= msg_len)};
                        have  = 1'b1;
                        done  = (emitted >= msg_len);
                        shift = '0;
                        pos   = BODY_START;
                    end else begin
                        pos++;
                    end
                end
                // early end gives a truncation unless this byte already ended the file
                if (fe && !done) begin
                    r    = '{message_char: 8'h00, status: ST_TRUNC, last: 1'b1};
                    have = 1'b1;
                end
            end
            if (fe)
                restart();
            if (have)
                awaited.push_back(r);
        endfunction

        function void check_result(logic [7:0] mc, logic [2:0] st, logic lst);
            t_result exp;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: char %h status %0d last %b", mc, st, lst);
                return;
            end
            exp = awaited.pop_front();
            checked++;
            if (int'(st) < 5)
                status_seen[st]++;
            if (mc !== exp.message_char || st !== exp.status || lst !== exp.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"result %0d: expected char %h status %0d last %b, ",
                              "got char %h status %0d last %b"},
                             checked, exp.message_char, exp.status, exp.last, mc, st, lst);
            end
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction

        function void close_out();
            if (awaited.size() != 0) begin
                mismatches += awaited.size();
                $display("%0d expected results never arrived", awaited.size());
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    lwe_item_if   item_ch ();
    lwe_result_if result_ch ();

    lsb_watermark_extract_top dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (item_ch),
        .o_result (result_ch)
    );

    WatermarkScoreboard sb = new();

    // Shared stimulus state
    int   burst_left;
    int   bytes_sent;
    int   files_sent;
    int   pressure_stalls;
    int   cycle_count;
    logic random_phase;
    logic hold_off;
    logic drain;

    // 4 ns clock
    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // File builders. Only bit 0 of each byte carries data; the upper bits
    // are random so every input bit toggles.
    // ------------------------------------------------------------------
    function automatic logic [7:0] carrier(input logic lsb);
        logic [7:0] b;
        b    = 8'($urandom);
        b[0] = lsb;
        return b;
    endfunction

    function automatic void put_bits(ref logic [7:0] q[$], input logic [31:0] val,
                                     input int n);
        for (int i = 0; i < n; i++)
            q.push_back(carrier(val[i]));
    endfunction

    // Header, signature (one bit flipped when bad) and length field
    function automatic void put_preamble(ref logic [7:0] q[$], input bit bad_sig,
                                         input logic [31:0] len);
        int         bad_k;
        int         bad_b;
        logic [7:0] c;
        bad_k = bad_sig ? $urandom_range(0, 8) : -1;
        bad_b = $urandom_range(0, 7);
        for (int i = 0; i < HEADER_BYTES; i++)
            q.push_back(8'($urandom));
        for (int k = 0; k < 9; k++) begin
            c = WATERMARK_SIG[k];
            if (k == bad_k)
                c[bad_b] = ~c[bad_b];
            put_bits(q, {24'h0, c}, 8);
        end
        put_bits(q, len, 32);
    endfunction

    // ------------------------------------------------------------------
    // Sender: bursts of random length, random gaps between them, and now
    // and then a very long burst with no idling at all.
    // ------------------------------------------------------------------
    task automatic new_burst();
        burst_left = ($urandom_range(0, 9) == 0) ? 600 : $urandom_range(1, 24);
    endtask

    task automatic send_byte(input logic [7:0] fb, input logic fe);
        item_ch.valid     <= 1'b1;
        item_ch.file_byte <= fb;
        item_ch.file_end  <= fe;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        burst_left--;
        if (burst_left <= 0) begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            new_burst();
        end
    endtask

    // Sends the first n bytes, file_end on the last; bytes past 'useful'
    // are trailing filler and do not count towards the byte target.
    task automatic send_file(ref logic [7:0] q[$], input int n, input int useful);
        for (int i = 0; i < n; i++) begin
            send_byte(q[i], i == n - 1);
            if (i < useful)
                bytes_sent++;
        end
        files_sent++;
    endtask

    // Directed file: first two message characters are 0x00 and 0xFF.
    // cut < 0 sends the whole file including trailing filler.
    task automatic directed_file(input bit bad_sig, input logic [31:0] len,
                                 input int n_chars, input int cut, input int trailing);
        logic [7:0] q[$];
        logic [7:0] ch;
        int         useful;
        put_preamble(q, bad_sig, len);
        for (int i = 0; i < n_chars; i++) begin
            ch = (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom);
            put_bits(q, {24'h0, ch}, 8);
        end
        useful = q.size();
        for (int i = 0; i < trailing; i++)
            q.push_back(8'($urandom));
        send_file(q, (cut < 0) ? q.size() : cut, useful);
    endtask

    // Mostly well-formed files with random content; the rest are bad
    // signatures, empty and oversize lengths, truncations and pure noise.
    task automatic random_file(input bit force_long);
        logic [7:0]  q[$];
        logic [31:0] len;
        int          kind;
        int          useful;
        int          cut;
        kind = force_long ? 99 : $urandom_range(0, 99);
        if (kind < 4) begin
            for (int i = $urandom_range(1, 400); i > 0; i--)
                q.push_back(8'($urandom));
            useful = q.size();
        end else begin
            if (kind < 12)
                len = $urandom_range(1, 4);
            else if (kind < 18)
                len = '0;
            else if (kind < 24) begin
                case ($urandom_range(0, 3))
                    0:       len = 32'hFFFF_FFFF;
                    1:       len = MAX_MESSAGE_CHARS + 1;
                    2:       len = {1'b1, 31'($urandom)};
                    default: len = MAX_MESSAGE_CHARS + 1 + $urandom_range(0, 65535);
                endcase
            end else if (force_long)
                len = 40;
            else
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48)
                                                  : $urandom_range(1, 12);
            put_preamble(q, kind < 12, len);
            if (kind >= 24 || kind < 12)
                for (int i = 0; i < len; i++)
                    put_bits(q, 32'($urandom), 8);
            useful = (kind >= 24) ? q.size()
                   : (kind < 12)  ? HEADER_BYTES + SIG_BYTES : BODY_START;
        end
        for (int i = $urandom_range(0, 6); i > 0; i--)
            q.push_back(8'($urandom));
        cut = q.size();
        if (kind >= 24 && !force_long && $urandom_range(0, 5) == 0)
            cut = $urandom_range(1, useful);
        send_file(q, cut, useful);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        item_ch.valid     <= 1'b0;
        item_ch.file_byte <= 8'h00;
        item_ch.file_end  <= 1'b0;
        random_phase      <= 1'b0;
        drain             <= 1'b0;
        rst_n             <= 1'b0;
        bytes_sent = 0;
        files_sent = 0;
        new_burst();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed files
        directed_file(0, 1, 1, -1, 0);                    // ends on the final char byte
        directed_file(0, 3, 3, -1, 5);                    // trailing bytes ignored
        directed_file(1, 2, 0, -1, 3);                    // bad signature
        directed_file(1, 2, 0, HEADER_BYTES + SIG_BYTES, 0); // ends with the no-sig
        directed_file(0, 0, 0, -1, 2);                    // empty message
        directed_file(0, 0, 0, BODY_START, 0);            // ends with the empty status
        directed_file(0, MAX_MESSAGE_CHARS + 1, 0, -1, 1); // just over the bound
        directed_file(0, 32'hFFFF_FFFF, 0, -1, 0);        // largest length
        directed_file(0, MAX_MESSAGE_CHARS, 3, BODY_START + 24, 0); // at bound, cut short
        directed_file(0, 5, 5, 1, 0);                     // one-byte file
        directed_file(0, 5, 5, HEADER_BYTES, 0);          // ends inside the header
        directed_file(0, 5, 5, 140, 0);                   // ends inside the length
        directed_file(0, 2, 2, BODY_START + 3, 0);        // ends mid character
        directed_file(0, 2, 2, BODY_START + 8, 0);        // end replaces a char

        // Random part; the first file is long so the hold-off backs it up
        random_phase <= 1'b1;
        random_file(1'b1);
        while (bytes_sent < ITEM_TARGET)
            random_file(1'b0);

        // Drain
        item_ch.valid <= 1'b0;
        drain         <= 1'b1;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (END_PAUSE) @(posedge clk);
        sb.close_out();

        $display("Covered %0d files, %0d file bytes; input held %0d cycles",
                 files_sent, bytes_sent, pressure_stalls);
        $display("  in a %0d-cycle hold-off", HOLD_CYCLES);
        $display({"Checked %0d results: %0d chars, %0d no-sig, %0d too-long, ",
                  "%0d empty, %0d truncated"},
                 sb.checked, sb.status_seen[0], sb.status_seen[1], sb.status_seen[2],
                 sb.status_seen[3], sb.status_seen[4]);
        if (sb.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: picks a new stall pattern whenever the current one runs out.
    // hold_off forces a long stall; drain keeps it ready at the end.
    // ------------------------------------------------------------------
    initial begin
        int mode;
        int left;
        result_ch.ready <= 1'b0;
        mode = 0;
        left = 0;
        forever begin
            @(posedge clk);
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(32, 256);
            end
            left--;
            if (drain)
                result_ch.ready <= 1'b1;
            else if (hold_off)
                result_ch.ready <= 1'b0;
            else begin
                case (mode)
                    0:       result_ch.ready <= 1'b1;
                    1:       result_ch.ready <= 1'($urandom_range(0, 1));
                    2:       result_ch.ready <= ($urandom_range(0, 4) == 0);
                    default: result_ch.ready <= (left[1:0] == 2'd0);
                endcase
            end
        end
    end

    // Long hold-off early in the random part: the sender keeps offering
    // bytes, so the result register fills and the input has to back up.
    initial begin
        hold_off <= 1'b0;
        wait (random_phase === 1'b1);
        repeat (40) @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Transfer monitors; values are the ones present just before the edge
    always @(posedge clk) begin
        if (rst_n && item_ch.valid && item_ch.ready)
            sb.note_byte(item_ch.file_byte, item_ch.file_end);
        if (rst_n && result_ch.valid && result_ch.ready)
            sb.check_result(result_ch.message_char, result_ch.status, result_ch.last);
        if (hold_off && item_ch.valid && !item_ch.ready)
            pressure_stalls++;
    end

    // Watchdog
    initial begin
        cycle_count     = 0;
        pressure_stalls = 0;
        while (cycle_count <= CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles", CYCLE_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

endmodule

/* sim.f */
hdl/lwe_pkg.sv
hdl/lwe_if.sv
hdl/lwe_in_reg.sv
hdl/lwe_core.sv
hdl/lwe_out_reg.sv
hdl/lsb_watermark_extract_top.sv
verif/tb_lsb_watermark_extract_top.sv
